>>> hdl/synapse_short_term_plasticity_top_assert.svh
// Assertion macros shared by the synapse plasticity block.
`ifndef SYNAPSE_SHORT_TERM_PLASTICITY_TOP_ASSERT_SVH
`define SYNAPSE_SHORT_TERM_PLASTICITY_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define STP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stp: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define STP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stp: next-cycle check failed");

`endif

>>> hdl/stp_pkg.sv
// Shared constants, types and helpers of the synapse plasticity block.
package stp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LVL_W     = 20;
  localparam int RATE_W    = 17;
  localparam int PROB_W    = 17;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 6;
  localparam int SAMPLE_W  = 16;
  localparam int CMD_W     = 3;
  localparam int ACC_W     = 41;
  localparam int MUL_B_W   = 21;
  localparam int NUM_W     = LVL_W + FRAC_BITS;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int MAX_SYNAPSES_DEF = 64;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [ACC_W-1:0]  acc_t;

  localparam lvl_t  LVL_ONE  = LVL_W'(1 << FRAC_BITS);
  localparam lvl_t  LVL_MAX  = '1;
  localparam rate_t RATE_ONE = RATE_W'(1 << FRAC_BITS);
  localparam acc_t  PROD_CAP = ACC_W'(64'd1 << (ACC_W - 1));

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT_PR = 3'd0,
    CMD_INIT_F  = 3'd1,
    CMD_INIT_D1 = 3'd2,
    CMD_INIT_D2 = 3'd3,
    CMD_REINIT  = 3'd4,
    CMD_TICK    = 3'd5,
    CMD_SPIKE   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    REG_DELTA_F     = 3'd0,
    REG_FAST_FACTOR = 3'd1,
    REG_SLOW_FACTOR = 3'd2,
    REG_RATE_F      = 3'd3,
    REG_RATE_FAST   = 3'd4,
    REG_RATE_SLOW   = 3'd5,
    REG_SYN_COUNT   = 3'd6
  } reg_idx_t;

  // Running state of one synapse.
  typedef struct packed {
    lvl_t scale;
    lvl_t slow;
    lvl_t fast;
    lvl_t facil;
  } syn_state_t;

  // Initial values of one synapse.
  typedef struct packed {
    lvl_t slow;
    lvl_t fast;
    lvl_t facil;
    lvl_t prob;
  } syn_init_t;

  // Clamp a wide value to the largest level code.
  function automatic lvl_t sat_level(input acc_t v);
    return (v > acc_t'(LVL_MAX)) ? LVL_MAX : v[LVL_W-1:0];
  endfunction

endpackage

>>> hdl/stp_if.sv
// Request and response channel interfaces of the synapse plasticity block.
interface stp_req_if import stp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    synapse_index;
  logic [LVL_W-1:0]    value;
  logic [SAMPLE_W-1:0] random_sample;

  modport source(output valid, command, synapse_index, value, random_sample, input ready);
  modport sink(input valid, command, synapse_index, value, random_sample, output ready);
endinterface

interface stp_rsp_if import stp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              released;
  logic [PROB_W-1:0] release_probability;
  logic              index_error;

  modport source(output valid, released, release_probability, index_error, input ready);
  modport sink(input valid, released, release_probability, index_error, output ready);
endinterface

>>> hdl/stp_ram.sv
// Generic simple dual-port RAM with a registered read.
module stp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/stp_mul.sv
// Capped fixed-point multiplier built from two half-width partial products.
module stp_mul import stp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  acc_t               a,
  input  logic [MUL_B_W-1:0] b,
  output acc_t               res,
  output logic               done,
  output logic               busy
);

  localparam int HI_W   = ACC_W - MUL_B_W;
  localparam int PROD_W = 2 * MUL_B_W;
  localparam int SUM_W  = ACC_W + MUL_B_W + 1;
  localparam int SHR_W  = SUM_W - FRAC_BITS;

  typedef enum logic [1:0] {P_IDLE, P_LO, P_HI, P_SUM} phase_t;

  phase_t              phase;
  acc_t                a_r;
  logic [MUL_B_W-1:0]  b_r;
  logic [PROD_W-1:0]   lo_r;
  logic [PROD_W-1:0]   hi_r;
  logic [MUL_B_W-1:0]  m_x;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic [SHR_W-1:0]    shifted;

  // One shared multiplier: low half of a first, then the high half.
  assign m_x  = (phase == P_LO) ? a_r[MUL_B_W-1:0] : MUL_B_W'(a_r[ACC_W-1:MUL_B_W]);
  assign prod = m_x * b_r;

  // Recombine the halves, drop the fraction, cap the result.
  assign sum     = SUM_W'({hi_r[HI_W+MUL_B_W-1:0], {MUL_B_W{1'b0}}}) + SUM_W'(lo_r);
  assign shifted = sum[SUM_W-1:FRAC_BITS];
  assign busy    = (phase != P_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            phase <= P_LO;
          end
        end
        P_LO: begin
          lo_r  <= prod;
          phase <= P_HI;
        end
        P_HI: begin
          hi_r  <= prod;
          phase <= P_SUM;
        end
        P_SUM: begin
          res   <= (shifted > SHR_W'(PROD_CAP)) ? PROD_CAP : shifted[ACC_W-1:0];
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/stp_div.sv
// Restoring divider for the release scale, one quotient bit per cycle, saturating.
module stp_div import stp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  acc_t             den,
  output lvl_t             q,
  output logic             done
);

  localparam int CW = $clog2(LVL_W + 1);
  localparam int TW = ACC_W + 1;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t          dstate;
  logic [CW-1:0]    cnt;
  acc_t             rem;
  acc_t             den_r;
  lvl_t             low;
  acc_t             num_hi;
  logic [TW-1:0]    trial;
  logic [TW-1:0]    diff;
  logic             fits;

  assign num_hi = acc_t'(num[NUM_W-1:LVL_W]);
  assign trial  = {rem, low[LVL_W-1]};
  assign diff   = trial - {1'b0, den_r};
  assign fits   = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            // A zero divisor or a quotient of 2^20 or more saturates at once.
            if ((den == '0) || (num_hi >= den)) begin
              q    <= LVL_MAX;
              done <= 1'b1;
            end else begin
              rem    <= num_hi;
              low    <= num[LVL_W-1:0];
              den_r  <= den;
              q      <= '0;
              cnt    <= CW'(LVL_W);
              dstate <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
          q   <= {q[LVL_W-2:0], fits};
          low <= {low[LVL_W-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/synapse_short_term_plasticity_top.sv
// Top level of the short-term plasticity synapse bank: sequencer, registers, memories.
//
//   channel   direction  payload
//   req       in         command, synapse_index, value, random_sample
//   rsp       out        released, release_probability, index_error
//   apb       in/out     seven configuration registers at byte address 4*i
//
// One request is worked at a time; all multiplies go through one shared unit.
// A spike does five multiplies in a row. Tick and reinit both walk the state memory
// over the active synapses, one synapse at a time, through the shared multiplier.
// After reset a clearing pass loads 1.0 into every entry.
// A response waiting on rsp does not block taking the next request.
`include "synapse_short_term_plasticity_top_assert.svh"
module synapse_short_term_plasticity_top import stp_pkg::*; #(
  parameter int MAX_SYNAPSES = MAX_SYNAPSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  stp_req_if.sink           req,
  stp_rsp_if.source         rsp
);

  localparam int AW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
  localparam int NW = ($clog2(MAX_SYNAPSES + 1) > CNT_W) ? $clog2(MAX_SYNAPSES + 1) : CNT_W;
  localparam logic [NW-1:0] MAX_N  = NW'(MAX_SYNAPSES);
  localparam logic [NW-1:0] LAST_N = NW'(MAX_SYNAPSES - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_MUL_GO, S_MUL_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_WRITE, S_FIN
  } state_t;

  // Configuration registers.
  lvl_t              delta_f;
  rate_t             fast_factor;
  rate_t             slow_factor;
  rate_t             rate_f;
  rate_t             rate_fast;
  rate_t             rate_slow;
  logic [CNT_W-1:0]  syn_count;

  // Sequencer state and working registers.
  state_t            state;
  logic [NW-1:0]     ptr;
  logic [NW-1:0]     n_r;
  cmd_t              cmd_r;
  lvl_t              val_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [2:0]        step;
  logic              gain_ph;
  lvl_t              facil;
  lvl_t              fast_lvl;
  lvl_t              slow_lvl;
  lvl_t              scale;
  syn_init_t         init_r;
  acc_t              acc;
  rate_t             gain_f;
  rate_t             gain_fast;
  rate_t             gain_slow;
  logic              res_released;
  logic [PROB_W-1:0] res_prob;
  logic              res_err;
  logic              out_valid;
  logic              out_released;
  logic [PROB_W-1:0] out_prob;
  logic              out_err;

  // Combinational signals.
  reg_idx_t          cfg_sel;
  logic              cfg_wr;
  logic [NW-1:0]     count_ext;
  logic [NW-1:0]     n_act;
  logic [NW-1:0]     idx_ext;
  logic              req_acc;
  logic              idx_cmd;
  logic              bad_idx;
  syn_state_t        st_rd;
  syn_state_t        st_wd;
  syn_init_t         in_rd;
  syn_init_t         in_wd;
  logic              st_we;
  logic              in_we;
  acc_t              mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic              mul_start;
  acc_t              mul_res;
  logic              mul_done;
  logic              mul_busy;
  logic              div_start;
  lvl_t              div_q;
  logic              div_done;
  rate_t             rf_c;
  rate_t             r1_c;
  rate_t             r2_c;
  rate_t             gain_val;
  logic [PROB_W-1:0] prob_c;

  function automatic acc_t dist_one(input lvl_t x);
    return (x < LVL_ONE) ? acc_t'(LVL_ONE - x) : acc_t'(x - LVL_ONE);
  endfunction

  function automatic lvl_t relax(input lvl_t x, input acc_t stp);
    return (x < LVL_ONE) ? (x + stp[LVL_W-1:0]) : (x - stp[LVL_W-1:0]);
  endfunction

  // APB register file; writes complete in the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_sel)
      REG_DELTA_F:     prdata = DATA_W'(delta_f);
      REG_FAST_FACTOR: prdata = DATA_W'(fast_factor);
      REG_SLOW_FACTOR: prdata = DATA_W'(slow_factor);
      REG_RATE_F:      prdata = DATA_W'(rate_f);
      REG_RATE_FAST:   prdata = DATA_W'(rate_fast);
      REG_RATE_SLOW:   prdata = DATA_W'(rate_slow);
      REG_SYN_COUNT:   prdata = DATA_W'(syn_count);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_f     <= '0;
      fast_factor <= RATE_ONE;
      slow_factor <= RATE_ONE;
      rate_f      <= '0;
      rate_fast   <= '0;
      rate_slow   <= '0;
      syn_count   <= CNT_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DELTA_F:     delta_f     <= pwdata[LVL_W-1:0];
        REG_FAST_FACTOR: fast_factor <= pwdata[RATE_W-1:0];
        REG_SLOW_FACTOR: slow_factor <= pwdata[RATE_W-1:0];
        REG_RATE_F:      rate_f      <= pwdata[RATE_W-1:0];
        REG_RATE_FAST:   rate_fast   <= pwdata[RATE_W-1:0];
        REG_RATE_SLOW:   rate_slow   <= pwdata[RATE_W-1:0];
        REG_SYN_COUNT:   syn_count   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode and index check against the active count.
  assign count_ext = NW'(syn_count);
  assign n_act     = (count_ext > MAX_N) ? MAX_N : count_ext;
  assign idx_ext   = NW'(req.synapse_index);
  assign req_acc   = req.valid & req.ready;
  assign idx_cmd   = (req.command == CMD_INIT_PR) || (req.command == CMD_INIT_F) ||
                     (req.command == CMD_INIT_D1) || (req.command == CMD_INIT_D2) ||
                     (req.command == CMD_SPIKE);
  assign bad_idx   = (idx_ext >= n_act);
  assign req.ready = (state == S_IDLE);

  // Clamped rates for the relaxation gains.
  assign rf_c = (rate_f > RATE_ONE) ? RATE_ONE : rate_f;
  assign r1_c = (rate_fast > RATE_ONE) ? RATE_ONE : rate_fast;
  assign r2_c = (rate_slow > RATE_ONE) ? RATE_ONE : rate_slow;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_r)
      CMD_SPIKE: begin
        unique case (step)
          3'd0:    begin mul_a = acc_t'(fast_lvl); mul_b = MUL_B_W'(fast_factor); end
          3'd1:    begin mul_a = acc_t'(slow_lvl); mul_b = MUL_B_W'(slow_factor); end
          3'd2:    begin mul_a = acc_t'(scale);    mul_b = MUL_B_W'(facil);       end
          3'd3:    begin mul_a = acc;              mul_b = MUL_B_W'(fast_lvl);    end
          3'd4:    begin mul_a = acc;              mul_b = MUL_B_W'(slow_lvl);    end
          default: ;
        endcase
      end
      CMD_REINIT: begin
        mul_a = acc;
        unique case (step)
          3'd0:    mul_b = MUL_B_W'(fast_lvl);
          3'd1:    mul_b = MUL_B_W'(fast_factor);
          3'd2:    mul_b = MUL_B_W'(slow_lvl);
          3'd3:    mul_b = MUL_B_W'(slow_factor);
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (gain_ph) begin
          unique case (step)
            3'd0:    begin mul_a = acc_t'(rf_c); mul_b = MUL_B_W'(rf_c); end
            3'd1:    begin mul_a = acc_t'(r1_c); mul_b = MUL_B_W'(r1_c); end
            3'd2:    begin mul_a = acc_t'(r2_c); mul_b = MUL_B_W'(r2_c); end
            default: ;
          endcase
        end else begin
          unique case (step)
            3'd0:    begin mul_a = dist_one(facil);    mul_b = MUL_B_W'(gain_f);    end
            3'd1:    begin mul_a = dist_one(fast_lvl); mul_b = MUL_B_W'(gain_fast); end
            3'd2:    begin mul_a = dist_one(slow_lvl); mul_b = MUL_B_W'(gain_slow); end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Gain r - r*r/2 from the squared clamped rate.
  assign gain_val = mul_a[RATE_W-1:0] - mul_res[RATE_W:1];

  // Spike probability capped at 1.0.
  assign prob_c = (acc > acc_t'(LVL_ONE)) ? PROB_W'(LVL_ONE) : acc[PROB_W-1:0];

  // Memory write ports: clearing pass, state write-back, initial value merge.
  assign st_we = (state == S_CLEAR) || (state == S_WRITE);
  assign st_wd = (state == S_CLEAR) ? syn_state_t'({4{LVL_ONE}}) :
                 syn_state_t'{scale: scale, slow: slow_lvl, fast: fast_lvl, facil: facil};
  assign in_we = (state == S_CLEAR) ||
                 ((state == S_LOAD) && ((cmd_r == CMD_INIT_PR) || (cmd_r == CMD_INIT_F) ||
                  (cmd_r == CMD_INIT_D1) || (cmd_r == CMD_INIT_D2)));

  always_comb begin
    in_wd = in_rd;
    if (state == S_CLEAR) begin
      in_wd = syn_init_t'({4{LVL_ONE}});
    end else begin
      unique case (cmd_r)
        CMD_INIT_PR: in_wd.prob  = val_r;
        CMD_INIT_F:  in_wd.facil = val_r;
        CMD_INIT_D1: in_wd.fast  = val_r;
        CMD_INIT_D2: in_wd.slow  = val_r;
        default: ;
      endcase
    end
  end

  assign mul_start = (state == S_MUL_GO);
  assign div_start = (state == S_DIV_GO);

  stp_ram #(.WIDTH($bits(syn_state_t)), .DEPTH(MAX_SYNAPSES)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (ptr[AW-1:0]),
    .wdata (st_wd),
    .raddr (ptr[AW-1:0]),
    .rdata (st_rd)
  );

  stp_ram #(.WIDTH($bits(syn_init_t)), .DEPTH(MAX_SYNAPSES)) u_init_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (ptr[AW-1:0]),
    .wdata (in_wd),
    .raddr (ptr[AW-1:0]),
    .rdata (in_rd)
  );

  stp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res),
    .done  (mul_done),
    .busy  (mul_busy)
  );

  stp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({init_r.prob, {FRAC_BITS{1'b0}}}),
    .den   (acc),
    .q     (div_q),
    .done  (div_done)
  );

  // Sequencer: one request at a time, read-modify-write through the memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      step      <= '0;
      gain_ph   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The response register is reloaded in S_FIN, so it is only emptied elsewhere.
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (ptr == LAST_N) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + NW'(1);
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            cmd_r        <= cmd_t'(req.command);
            val_r        <= req.value;
            sample_r     <= req.random_sample;
            n_r          <= n_act;
            step         <= '0;
            res_released <= 1'b0;
            res_prob     <= '0;
            res_err      <= 1'b0;
            if (idx_cmd) begin
              if (bad_idx) begin
                res_err <= 1'b1;
                state   <= S_FIN;
              end else begin
                ptr   <= idx_ext;
                state <= S_READ;
              end
            end else if (req.command == CMD_REINIT) begin
              ptr   <= '0;
              state <= (n_act == '0) ? S_FIN : S_READ;
            end else if (req.command == CMD_TICK) begin
              ptr <= '0;
              if (n_act == '0) begin
                state <= S_FIN;
              end else begin
                gain_ph <= 1'b1;
                state   <= S_MUL_GO;
              end
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          unique case (cmd_r)
            CMD_SPIKE: begin
              facil    <= sat_level(acc_t'(st_rd.facil) + acc_t'(delta_f));
              fast_lvl <= st_rd.fast;
              slow_lvl <= st_rd.slow;
              scale    <= st_rd.scale;
              state    <= S_MUL_GO;
            end
            CMD_REINIT: begin
              facil    <= in_rd.facil;
              fast_lvl <= in_rd.fast;
              slow_lvl <= in_rd.slow;
              init_r   <= in_rd;
              acc      <= acc_t'(in_rd.facil) + acc_t'(delta_f);
              step     <= '0;
              state    <= S_MUL_GO;
            end
            CMD_TICK: begin
              facil    <= st_rd.facil;
              fast_lvl <= st_rd.fast;
              slow_lvl <= st_rd.slow;
              scale    <= st_rd.scale;
              step     <= '0;
              state    <= S_MUL_GO;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            state <= S_MUL_GO;
            step  <= step + 3'd1;
            unique case (cmd_r)
              CMD_SPIKE: begin
                unique case (step)
                  3'd0:    fast_lvl <= sat_level(mul_res);
                  3'd1:    slow_lvl <= sat_level(mul_res);
                  3'd4:    begin acc <= mul_res; state <= S_WRITE; end
                  default: acc <= mul_res;
                endcase
              end
              CMD_REINIT: begin
                acc <= mul_res;
                if (step == 3'd3) begin
                  state <= S_DIV_GO;
                end
              end
              CMD_TICK: begin
                if (gain_ph) begin
                  unique case (step)
                    3'd0:    gain_f    <= gain_val;
                    3'd1:    gain_fast <= gain_val;
                    default: gain_slow <= gain_val;
                  endcase
                  if (step == 3'd2) begin
                    gain_ph <= 1'b0;
                    state   <= S_READ;
                  end
                end else begin
                  unique case (step)
                    3'd0:    facil    <= relax(facil, mul_res);
                    3'd1:    fast_lvl <= relax(fast_lvl, mul_res);
                    default: slow_lvl <= relax(slow_lvl, mul_res);
                  endcase
                  if (step == 3'd2) begin
                    state <= S_WRITE;
                  end
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            scale <= div_q;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (cmd_r == CMD_SPIKE) begin
            res_prob     <= prob_c;
            res_released <= ({1'b0, sample_r} < prob_c);
            state        <= S_FIN;
          end else if ((ptr + NW'(1)) == n_r) begin
            state <= S_FIN;
          end else begin
            ptr   <= ptr + NW'(1);
            state <= S_READ;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_released <= res_released;
            out_prob     <= res_prob;
            out_err      <= res_err;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response register drives the output channel.
  assign rsp.valid               = out_valid;
  assign rsp.released            = out_released;
  assign rsp.release_probability = out_prob;
  assign rsp.index_error         = out_err;

  // A bad index goes straight to the response with the error flag.
  `STP_ASSERT_NXT(a_bad_index, req_acc && idx_cmd && bad_idx, (state == S_FIN) && res_err)
  // Memories are written only while a request is being worked or cleared.
  `STP_ASSERT_IMP(a_idle_no_write, state == S_IDLE, !st_we && !in_we)
  // The multiplier is never restarted while it is busy.
  `STP_ASSERT_IMP(a_mul_free, mul_start, !mul_busy)
  // Memory reads for a request stay inside the active synapses.
  `STP_ASSERT_IMP(a_ptr_range, state == S_READ, ptr < n_r)
  // A release never comes with an index error or a zero probability.
  `STP_ASSERT_IMP(a_release_clean, rsp.valid && rsp.released, !rsp.index_error && (rsp.release_probability != '0))

endmodule
